>>> sv/arp_ct_pkg.sv
// Package for the ARP cache table: widths, request and status codes, limits.
package arp_ct_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int IP_W            = 32;
    localparam int MAC_W           = 48;
    localparam int REQ_W           = 3;
    localparam int STATUS_W        = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 3'd0,
        REQ_RM_IP  = 3'd1,
        REQ_RM_MAC = 3'd2,
        REQ_LOOKUP = 3'd3,
        REQ_LIST   = 3'd4
    } t_req_type;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

endpackage

>>> sv/arp_ct_cam.sv
// Binding table: per-slot IP/MAC registers, parallel key compares, one-hot reads.
module arp_ct_cam #(
    parameter int DEPTH = arp_ct_pkg::TABLE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [arp_ct_pkg::IP_W-1:0]  i_ip_key,
    input  logic [arp_ct_pkg::MAC_W-1:0] i_mac_key,
    input  logic [DEPTH-1:0]             i_set_mask,   // claim slot, write IP
    input  logic [DEPTH-1:0]             i_macw_mask,  // write MAC
    input  logic [DEPTH-1:0]             i_clr_mask,   // release slot
    input  logic [DEPTH-1:0]             i_rd_ip_sel,  // one-hot or zero
    input  logic [DEPTH-1:0]             i_rd_mac_sel, // one-hot or zero
    output logic [DEPTH-1:0]             o_ip_match,
    output logic [DEPTH-1:0]             o_mac_match,
    output logic [DEPTH-1:0]             o_free,
    output logic [arp_ct_pkg::IP_W-1:0]  o_rd_ip,
    output logic [arp_ct_pkg::MAC_W-1:0] o_rd_mac
);
    import arp_ct_pkg::*;

    logic [DEPTH-1:0] r_valid;
    logic [IP_W-1:0]  r_ip  [DEPTH];
    logic [MAC_W-1:0] r_mac [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= (r_valid & ~i_clr_mask) | i_set_mask;
        end
    end

    // Payload: no reset, only read where valid.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i_set_mask[i]) begin
                r_ip[i] <= i_ip_key;
            end
            if (i_macw_mask[i]) begin
                r_mac[i] <= i_mac_key;
            end
        end
    end

    always_comb begin
        o_rd_ip  = '0;
        o_rd_mac = '0;
        for (int i = 0; i < DEPTH; i++) begin
            o_ip_match[i]  = r_valid[i] && (r_ip[i] == i_ip_key);
            o_mac_match[i] = r_valid[i] && (r_mac[i] == i_mac_key);
            o_rd_ip        = o_rd_ip  | (r_ip[i]  & {IP_W{i_rd_ip_sel[i]}});
            o_rd_mac       = o_rd_mac | (r_mac[i] & {MAC_W{i_rd_mac_sel[i]}});
        end
    end

    assign o_free = ~r_valid;

endmodule

>>> sv/arp_cache_table_core.sv
// ARP cache table top level: request register, request decode, result register.
//
//  channel  | signals                                   | dir | transfer
//  ---------+-------------------------------------------+-----+---------------------------
//  request  | i_req_type, i_ip_key, i_mac_key           | in  | start & !busy at clk edge
//  result   | o_status, o_mac_found, o_ip_found, o_last | out | o_valid, one cycle, no stall
//
// Flow: a request is taken into the request register, decoded against the table
// in the next cycle, and its result is registered and shown on the result ports
// in the cycle after. Add, remove, lookup and unknown codes go back to back.
// A list request keeps busy high from its transfer until its last result is
// registered: one result per cycle, max(1, min(matches, MAX_RESULTS)) results.
// Reset (i_rst_n low, synchronous) empties the table.
// The receiver cannot stall: every result is taken in the cycle it is shown.
module arp_cache_table_core #(
    parameter int TABLE_DEPTH = arp_ct_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [arp_ct_pkg::REQ_W-1:0]      i_req_type,
    input  logic [arp_ct_pkg::IP_W-1:0]       i_ip_key,
    input  logic [arp_ct_pkg::MAC_W-1:0]      i_mac_key,
    output logic                              o_valid,
    output logic [arp_ct_pkg::STATUS_W-1:0]   o_status,
    output logic [arp_ct_pkg::MAC_W-1:0]      o_mac_found,
    output logic [arp_ct_pkg::IP_W-1:0]       o_ip_found,
    output logic                              o_last
);
    import arp_ct_pkg::*;

    localparam int CNT_W = $clog2(MAX_RESULTS + 1);
    localparam logic [TABLE_DEPTH-1:0] ONE = TABLE_DEPTH'(1);

    // request register
    logic             r_req_vld;
    logic [REQ_W-1:0] r_req_type;
    logic [IP_W-1:0]  r_req_ip;
    logic [MAC_W-1:0] r_req_mac;

    // list walk state
    logic                   r_list_act, n_list_act;
    logic [TABLE_DEPTH-1:0] r_list_mask, n_list_mask;
    logic [CNT_W-1:0]       r_list_cnt, n_list_cnt;

    // result register
    logic                r_out_vld, n_out_vld;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [MAC_W-1:0]    r_mac_found, n_mac_found;
    logic [IP_W-1:0]     r_ip_found, n_ip_found;
    logic                r_last, n_last;

    // table interface
    logic [TABLE_DEPTH-1:0] set_mask, macw_mask, clr_mask, rd_ip_sel, rd_mac_sel;
    logic [TABLE_DEPTH-1:0] ip_match, mac_match, free_mask;
    logic [IP_W-1:0]        rd_ip;
    logic [MAC_W-1:0]       rd_mac;

    logic [TABLE_DEPTH-1:0] free_low, match_low, list_low, rest;
    logic                   accept;

    // No transfer while a list request waits in the request register or is walking.
    assign busy   = (r_req_vld && (r_req_type == REQ_LIST)) || r_list_act;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_type <= i_req_type;
            r_req_ip   <= i_ip_key;
            r_req_mac  <= i_mac_key;
        end
    end

    arp_ct_cam #(
        .DEPTH (TABLE_DEPTH)
    ) u_cam (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ip_key     (r_req_ip),
        .i_mac_key    (r_req_mac),
        .i_set_mask   (set_mask),
        .i_macw_mask  (macw_mask),
        .i_clr_mask   (clr_mask),
        .i_rd_ip_sel  (rd_ip_sel),
        .i_rd_mac_sel (rd_mac_sel),
        .o_ip_match   (ip_match),
        .o_mac_match  (mac_match),
        .o_free       (free_mask),
        .o_rd_ip      (rd_ip),
        .o_rd_mac     (rd_mac)
    );

    // lowest set bit, one-hot
    assign free_low  = free_mask   & (~free_mask   + ONE);
    assign match_low = mac_match   & (~mac_match   + ONE);
    assign list_low  = r_list_mask & (~r_list_mask + ONE);

    always_comb begin
        set_mask    = '0;
        macw_mask   = '0;
        clr_mask    = '0;
        rd_ip_sel   = '0;
        rd_mac_sel  = '0;
        rest        = '0;
        n_list_act  = r_list_act;
        n_list_mask = r_list_mask;
        n_list_cnt  = r_list_cnt;
        n_out_vld   = 1'b0;
        n_status    = ST_OK;
        n_mac_found = '0;
        n_ip_found  = '0;
        n_last      = 1'b1;

        if (r_list_act) begin
            // walk the remaining matches, lowest slot first
            rd_ip_sel   = list_low;
            rest        = r_list_mask & ~list_low;
            n_out_vld   = 1'b1;
            n_ip_found  = rd_ip;
            n_list_cnt  = r_list_cnt + CNT_W'(1);
            n_last      = (rest == '0) || (n_list_cnt == CNT_W'(MAX_RESULTS));
            n_list_mask = rest;
            n_list_act  = !n_last;
        end else if (r_req_vld) begin
            n_out_vld = 1'b1;
            unique case (r_req_type)
                REQ_ADD: begin
                    if (ip_match != '0) begin
                        macw_mask = ip_match;
                    end else if (free_mask != '0) begin
                        set_mask  = free_low;
                        macw_mask = free_low;
                    end else begin
                        n_status = ST_FULL;
                    end
                end
                REQ_RM_IP: begin
                    clr_mask = ip_match;
                    n_status = (ip_match != '0) ? ST_OK : ST_NOT_FOUND;
                end
                REQ_RM_MAC: begin
                    clr_mask = mac_match;
                    n_status = (mac_match != '0) ? ST_OK : ST_NOT_FOUND;
                end
                REQ_LOOKUP: begin
                    rd_mac_sel  = ip_match;     // at most one slot holds an IP
                    n_mac_found = rd_mac;
                    n_status    = (ip_match != '0) ? ST_OK : ST_NOT_FOUND;
                end
                REQ_LIST: begin
                    rd_ip_sel  = match_low;
                    rest       = mac_match & ~match_low;
                    n_ip_found = rd_ip;
                    if (mac_match == '0) begin
                        n_status = ST_NOT_FOUND;
                    end else begin
                        n_last      = (rest == '0) || (MAX_RESULTS == 1);
                        n_list_act  = !n_last;
                        n_list_mask = rest;
                        n_list_cnt  = CNT_W'(1);
                    end
                end
                default: begin
                    n_status = ST_NOT_FOUND;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_act <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_list_act <= n_list_act;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_list_mask <= n_list_mask;
        r_list_cnt  <= n_list_cnt;
        r_status    <= n_status;
        r_mac_found <= n_mac_found;
        r_ip_found  <= n_ip_found;
        r_last      <= n_last;
    end

    assign o_valid     = r_out_vld;
    assign o_status    = r_status;
    assign o_mac_found = r_mac_found;
    assign o_ip_found  = r_ip_found;
    assign o_last      = r_last;

`ifndef SYNTH
    // every accepted request shows its first result after the request and result registers
    a_req_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("accepted request produced no result");

    // list results are contiguous up to the final one
    a_list_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_valid)
        else $error("gap inside a list burst");

    // no transfer can sneak in while a list burst is still running
    a_list_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy)
        else $error("busy low during a list burst");

    // a full-table add is always a single, final result
    a_full_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |-> (o_last && (o_ip_found == '0)))
        else $error("table-full result not final");
`endif

endmodule
